// File: src/dcbe_pkg.sv
// ----------------------------------------------------------------------------
// dcbe_pkg
// Shared constants, types and permutation functions of the DES block unit.
// ----------------------------------------------------------------------------
package dcbe_pkg;

    localparam int ROUND_COUNT = 16;
    localparam int RK_AW       = 4;
    localparam int RK_W        = 48;

    localparam logic [1:0] REG_KEY   = 2'd0;
    localparam logic [1:0] REG_IV    = 2'd1;
    localparam logic [1:0] REG_CHAIN = 2'd2;

    typedef enum logic [1:0] {
        ST_KEYGEN,
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } ctrl_state_t;

    // key-schedule write request towards the round-key store
    typedef struct packed {
        logic                    wr_en;
        logic [RK_AW-1:0]        wr_addr;
        logic [RK_W-1:0]         wr_data;
    } rk_wr_t;

    typedef logic [7:0] tab64_t [64];
    typedef logic [7:0] tab56_t [56];
    typedef logic [7:0] tab48_t [48];
    typedef logic [7:0] tab32_t [32];
    typedef logic [3:0] sbox_t [8][64];

    localparam tab64_t IP_TAB = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam tab64_t FP_TAB = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam tab48_t EX_TAB = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam tab32_t PP_TAB = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam tab56_t PC1_TAB = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam tab48_t PC2_TAB = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100; // bit r: shift by 2

    localparam sbox_t SBOX = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // Bit numbering of the tables: 1 is the most significant bit.
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 64; k++) r[63-k] = v[64-IP_TAB[k]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 64; k++) r[63-k] = v[64-FP_TAB[k]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int k = 0; k < 56; k++) r[55-k] = v[64-PC1_TAB[k]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int k = 0; k < 48; k++) r[47-k] = v[56-PC2_TAB[k]];
        return r;
    endfunction

    // one round function: expand, mix key, substitute, permute
    function automatic logic [31:0] feistel(input logic [31:0] half,
                                            input logic [47:0] rk);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] r;
        logic [5:0]  six;
        for (int k = 0; k < 48; k++) x[47-k] = half[32-EX_TAB[k]];
        x = x ^ rk;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int k = 0; k < 32; k++) r[31-k] = s[32-PP_TAB[k]];
        return r;
    endfunction

endpackage

// File: src/dcbe_rk_ram.sv
// ----------------------------------------------------------------------------
// dcbe_rk_ram
// Round-key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcbe_rk_ram (
    input  logic                        aclk,
    input  dcbe_pkg::rk_wr_t            wr,
    input  logic [dcbe_pkg::RK_AW-1:0]  rd_addr,
    output logic [dcbe_pkg::RK_W-1:0]   rd_data
);
    logic [dcbe_pkg::RK_W-1:0] mem [dcbe_pkg::ROUND_COUNT];

    // write key, read registered
    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            mem[wr.wr_addr] <= wr.wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: src/dcbe_key_sched.sv
// ----------------------------------------------------------------------------
// dcbe_key_sched
// Derives the sixteen round keys from the key, one per cycle.
// ----------------------------------------------------------------------------
module dcbe_key_sched (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       des_key,
    output logic              busy,
    output dcbe_pkg::rk_wr_t  wr
);
    logic                       busy_reg, busy_next;
    logic [dcbe_pkg::RK_AW-1:0] idx_reg, idx_next;
    logic [27:0]                c_reg, c_next, d_reg, d_next;
    logic [27:0]                c_rot, d_rot;
    logic [55:0]                cd0;

    assign cd0 = dcbe_pkg::perm_pc1(des_key);

    // rotate by the schedule amount of this round
    always_comb begin
        if (dcbe_pkg::ROT_TWO[idx_reg]) begin
            c_rot = {c_reg[25:0], c_reg[27:26]};
            d_rot = {d_reg[25:0], d_reg[27:26]};
        end else begin
            c_rot = {c_reg[26:0], c_reg[27]};
            d_rot = {d_reg[26:0], d_reg[27]};
        end
    end

    // advance one round key per cycle
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            c_next    = cd0[55:28];
            d_next    = cd0[27:0];
        end else if (busy_reg) begin
            c_next   = c_rot;
            d_next   = d_rot;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == dcbe_pkg::RK_AW'(dcbe_pkg::ROUND_COUNT - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign busy       = busy_reg;
    assign wr.wr_en   = busy_reg && !start;
    assign wr.wr_addr = idx_reg;
    assign wr.wr_data = dcbe_pkg::perm_pc2({c_rot, d_rot});
endmodule

// File: src/dcbe_round_core.sv
// ----------------------------------------------------------------------------
// dcbe_round_core
// Pads, chains and runs one block through sixteen rounds, one per cycle.
// ----------------------------------------------------------------------------
module dcbe_round_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        keys_ready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 plain_block,
    input  logic [3:0]                  byte_count,
    input  logic                        restart_chain,
    input  logic [63:0]                 initial_vector,
    input  logic                        chain_enable,
    output logic [dcbe_pkg::RK_AW-1:0]  rk_addr,
    input  logic [dcbe_pkg::RK_W-1:0]   rk_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 cipher_block
);
    dcbe_pkg::ctrl_state_t      state_reg, state_next;
    logic [dcbe_pkg::RK_AW-1:0] rnd_reg, rnd_next;
    logic [31:0]                l_reg, l_next, r_reg, r_next;
    logic [63:0]                chain_reg, chain_next;
    logic [63:0]                out_reg, out_next;
    logic                       ovld_reg, ovld_next;
    logic [63:0]                padded, chained, ip_val, cipher;
    logic [63:0]                chain_src;
    logic [3:0]                 pad;
    logic                       accept, last_rnd;

    // pad missing bytes with their count
    always_comb begin
        padded = plain_block;
        pad    = 4'd8 - byte_count;
        for (int k = 0; k < 8; k++) begin
            if (byte_count < 4'd8 && k >= 32'(byte_count)) begin
                padded[56-8*k +: 8] = {4'd0, pad};
            end
        end
    end

    assign chain_src = restart_chain ? initial_vector : chain_reg;
    assign chained   = chain_enable ? (padded ^ chain_src) : padded;
    assign ip_val    = dcbe_pkg::perm_ip(chained);
    assign accept    = s_tvalid && s_tready;
    assign last_rnd  = rnd_reg == dcbe_pkg::RK_AW'(dcbe_pkg::ROUND_COUNT - 1);
    assign cipher    = dcbe_pkg::perm_fp({l_reg ^ dcbe_pkg::feistel(r_reg, rk_data), r_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dcbe_pkg::ST_KEYGEN: if (keys_ready) state_next = dcbe_pkg::ST_IDLE;
            dcbe_pkg::ST_IDLE:   if (!keys_ready) state_next = dcbe_pkg::ST_KEYGEN;
                                 else if (accept) state_next = dcbe_pkg::ST_ROUND;
            dcbe_pkg::ST_ROUND:  if (last_rnd) state_next = dcbe_pkg::ST_DONE;
            dcbe_pkg::ST_DONE:   if (!ovld_reg || m_tready) state_next = dcbe_pkg::ST_IDLE;
            default:             state_next = dcbe_pkg::ST_KEYGEN;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready   = (state_reg == dcbe_pkg::ST_IDLE) && keys_ready;
        rnd_next   = rnd_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        chain_next = chain_reg;
        out_next   = out_reg;
        ovld_next  = ovld_reg && !m_tready;
        rk_addr    = rnd_reg;
        case (state_reg)
            dcbe_pkg::ST_IDLE: begin
                rk_addr = '0;
                if (accept) begin
                    l_next   = ip_val[63:32];
                    r_next   = ip_val[31:0];
                    rnd_next = '0;
                    if (restart_chain) chain_next = initial_vector;
                end
            end
            dcbe_pkg::ST_ROUND: begin
                rk_addr = rnd_reg + 1'b1;
                if (!last_rnd) begin
                    l_next   = r_reg;
                    r_next   = l_reg ^ dcbe_pkg::feistel(r_reg, rk_data);
                    rnd_next = rnd_reg + 1'b1;
                end else begin
                    // hold the cipher until the output register frees
                    l_next = cipher[63:32];
                    r_next = cipher[31:0];
                    if (chain_enable) chain_next = cipher;
                end
            end
            dcbe_pkg::ST_DONE: begin
                if (!ovld_reg || m_tready) begin
                    out_next  = {l_reg, r_reg};
                    ovld_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcbe_pkg::ST_KEYGEN;
            ovld_reg  <= 1'b0;
            chain_reg <= '0;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
        end
        l_reg   <= l_next;
        r_reg   <= r_next;
        out_reg <= out_next;
    end

    assign m_tvalid     = ovld_reg;
    assign cipher_block = out_reg;
endmodule

// File: src/des_cbc_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// des_cbc_block_encrypt_unit
// DES block encryption with PKCS#5 padding and optional block chaining.
// ----------------------------------------------------------------------------
// Channel   | Ports      | Payload
// input     | s_axis     | tdata = plain_block[63:0]; tuser = byte_count[3:0], restart_chain[4]
// result    | m_axis     | tdata = cipher_block[63:0]
// config    | APB        | 0x0 des_key, 0x8 initial_vector, 0x10 chain_enable
//
// A result reaches the output register after its transfer by sixteen rounds
// through the shared round unit fed by the round-key memory, then a wait in the
// done state until the output register is free. The next block is accepted only
// once the result is in the output register. After reset and after each key write,
// the key schedule rebuilds all sixteen round keys before a block is accepted.
// A stalled result holds; the next block is accepted while it waits.
// ----------------------------------------------------------------------------
module des_cbc_block_encrypt_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // plain_block
    input  logic [7:0]  s_tuser,   // byte_count [3:0], restart_chain [4], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // cipher_block
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0]                key_reg, iv_reg;
    logic                       chain_reg;
    logic                       wr_fire, key_wr, rst_d_reg, start, sched_busy;
    logic [1:0]                 reg_idx;
    dcbe_pkg::rk_wr_t           rk_wr;
    logic [dcbe_pkg::RK_AW-1:0] rk_addr;
    logic [dcbe_pkg::RK_W-1:0]  rk_data;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && (paddr[2:0] == 3'd0);
    assign reg_idx = paddr[4:3];
    assign key_wr  = wr_fire && reg_idx == dcbe_pkg::REG_KEY;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            iv_reg    <= '0;
            chain_reg <= 1'b0;
            rst_d_reg <= 1'b1;
        end else begin
            rst_d_reg <= 1'b0;
            if (wr_fire) begin
                case (reg_idx)
                    dcbe_pkg::REG_KEY:   key_reg   <= pwdata;
                    dcbe_pkg::REG_IV:    iv_reg    <= pwdata;
                    dcbe_pkg::REG_CHAIN: chain_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            dcbe_pkg::REG_KEY:   prdata = key_reg;
            dcbe_pkg::REG_IV:    prdata = iv_reg;
            dcbe_pkg::REG_CHAIN: prdata = {63'd0, chain_reg};
            default:             prdata = '0;
        endcase
    end

    // rebuild round keys after reset and after a key write
    assign start = rst_d_reg || key_wr;

    dcbe_key_sched u_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .des_key (key_wr ? pwdata : key_reg),
        .busy    (sched_busy),
        .wr      (rk_wr)
    );

    dcbe_rk_ram u_ram (
        .aclk    (aclk),
        .wr      (rk_wr),
        .rd_addr (rk_addr),
        .rd_data (rk_data)
    );

    dcbe_round_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .keys_ready     (!sched_busy && !start),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .plain_block    (s_tdata),
        .byte_count     (s_tuser[3:0] > 4'd8 ? 4'd8 : s_tuser[3:0]),
        .restart_chain  (s_tuser[4]),
        .initial_vector (iv_reg),
        .chain_enable   (chain_reg),
        .rk_addr        (rk_addr),
        .rk_data        (rk_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cipher_block   (m_tdata)
    );
endmodule

// File: src/dcbe_checker.sv
// ----------------------------------------------------------------------------
// dcbe_checker
// Port-level checks of the DES block unit, bound to the top level.
// ----------------------------------------------------------------------------
module dcbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        pready
);
    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one block at a time: no second transfer right after one
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during rounds");

    // no result can appear shortly after a transfer
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 !m_tvalid)
        else $error("result appeared too early");

    // config port never waits
    a_rdy: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind des_cbc_block_encrypt_unit dcbe_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
